// ===== rtl/ddsort_pkg.sv =====
`timescale 1ns / 1ps

package ddsort_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TOL_W       = 10;
    localparam int CLASS_W     = 8;
    localparam int DIST_W      = 16;
    localparam int POS_W       = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(200);

    // request kinds
    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0]       class_id;
        logic [DIST_W-1:0]        distance_mm;
        logic signed [POS_W-1:0]  pos_x_mm;
        logic signed [POS_W-1:0]  pos_y_mm;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_SCAN,
        ST_DET_RES,
        ST_SEL_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/ddsort_in_if.sv =====
`timescale 1ns / 1ps

interface ddsort_in_if;
    import ddsort_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [CLASS_W-1:0]       class_id;
    logic [DIST_W-1:0]        distance_mm;
    logic signed [POS_W-1:0]  pos_x_mm;
    logic signed [POS_W-1:0]  pos_y_mm;

    modport source (
        output valid, kind, class_id, distance_mm, pos_x_mm, pos_y_mm,
        input  ready
    );

    modport sink (
        input  valid, kind, class_id, distance_mm, pos_x_mm, pos_y_mm,
        output ready
    );

endinterface

// ===== rtl/ddsort_out_if.sv =====
`timescale 1ns / 1ps

interface ddsort_out_if;
    import ddsort_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     stored;
    logic                     table_full;
    logic                     entry_valid;
    logic [CLASS_W-1:0]       out_class_id;
    logic [DIST_W-1:0]        out_distance_mm;
    logic signed [POS_W-1:0]  out_x_mm;
    logic signed [POS_W-1:0]  out_y_mm;
    logic                     last;

    modport source (
        output valid, stored, table_full, entry_valid, out_class_id,
               out_distance_mm, out_x_mm, out_y_mm, last,
        input  ready
    );

    modport sink (
        input  valid, stored, table_full, entry_valid, out_class_id,
               out_distance_mm, out_x_mm, out_y_mm, last,
        output ready
    );

endinterface

// ===== rtl/detection_dedup_distance_sorter_unit.sv =====
// detection request: result follows a duplicate scan over all n stored entries (0..16),
//   an empty table skips the compare, and a finish on an empty table goes straight to the result
// finish request: one selection scan over the table per emitted entry,
//   paced by the single read port of the entry memory, one entry compared per cycle
// one request at a time; a new request is taken while the previous result waits
// reset: asynchronous active low, table empty, tolerance 200 mm, entry memory not cleared
`timescale 1ns / 1ps

module detection_dedup_distance_sorter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ddsort_pkg::TOL_W-1:0]   cfg_wr_data,
    ddsort_in_if.sink                      det_in,
    ddsort_out_if.source                   res_out
);
    import ddsort_pkg::*;

    // sequencer and table bookkeeping
    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [CNT_W-1:0]    count_reg, count_next;

    // entry memory, one write and one registered read port
    entry_t              mem [TABLE_DEPTH];
    entry_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;

    // request held for the whole scan
    entry_t              new_reg, new_next;

    // scan pipeline: address issue, then compare on returned data
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                issue;
    logic                scan_done;

    // duplicate search
    logic                hit_reg, hit_next;
    logic [DIST_W-1:0]   diff;
    logic                match;

    // minimum selection for readout
    logic                best_found_reg, best_found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    entry_t              best_entry_reg, best_entry_next;
    logic [TABLE_DEPTH-1:0] done_mask_reg, done_mask_next;
    logic [CNT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                emit_last;
    logic                cand;

    // output register
    logic                ov_reg, ov_next;
    logic                o_stored_reg, o_stored_next;
    logic                o_full_reg, o_full_next;
    logic                o_valid_reg, o_valid_next;
    entry_t              o_entry_reg, o_entry_next;
    logic                o_last_reg, o_last_next;
    logic                slot_free;
    logic                det_accept;

    assign det_in.ready = (state_reg == ST_IDLE);
    assign det_accept   = det_in.valid && det_in.ready;
    assign slot_free    = !ov_reg || res_out.ready;

    assign res_out.valid           = ov_reg;
    assign res_out.stored          = o_stored_reg;
    assign res_out.table_full      = o_full_reg;
    assign res_out.entry_valid     = o_valid_reg;
    assign res_out.out_class_id    = o_entry_reg.class_id;
    assign res_out.out_distance_mm = o_entry_reg.distance_mm;
    assign res_out.out_x_mm        = o_entry_reg.pos_x_mm;
    assign res_out.out_y_mm        = o_entry_reg.pos_y_mm;
    assign res_out.last            = o_last_reg;

    // shared scan unit: one read issued per cycle while entries remain
    assign issue     = ((state_reg == ST_DUP_SCAN) || (state_reg == ST_SEL_SCAN))
                       && (scan_idx_reg < count_reg);
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];
    assign scan_done = !issue && !pend_reg;

    // absolute distance difference against the held detection
    assign diff  = (rd_data_reg.distance_mm >= new_reg.distance_mm)
                   ? (rd_data_reg.distance_mm - new_reg.distance_mm)
                   : (new_reg.distance_mm - rd_data_reg.distance_mm);
    assign match = (rd_data_reg.class_id == new_reg.class_id)
                   && (diff <= {{(DIST_W-TOL_W){1'b0}}, tol_reg});

    // strict less-than keeps equal distances in insertion order
    assign cand  = !done_mask_reg[pend_idx_reg]
                   && (!best_found_reg || (rd_data_reg.distance_mm < best_entry_reg.distance_mm));

    assign emit_last = ((emit_cnt_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        new_next        = new_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = issue;
        pend_idx_next   = rd_addr;
        hit_next        = hit_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        done_mask_next  = done_mask_reg;
        emit_cnt_next   = emit_cnt_reg;
        mem_we          = 1'b0;
        ov_next         = ov_reg && !res_out.ready;
        o_stored_next   = o_stored_reg;
        o_full_next     = o_full_reg;
        o_valid_next    = o_valid_reg;
        o_entry_next    = o_entry_reg;
        o_last_next     = o_last_reg;

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (det_accept)
                begin
                    new_next.class_id    = det_in.class_id;
                    new_next.distance_mm = det_in.distance_mm;
                    new_next.pos_x_mm    = det_in.pos_x_mm;
                    new_next.pos_y_mm    = det_in.pos_y_mm;
                    scan_idx_next        = '0;
                    if (det_in.kind == KIND_DETECT)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_DUP_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty finish answers like a duplicate: all zero, last set
                        hit_next   = 1'b1;
                        state_next = ST_DET_RES;
                    end
                    else
                    begin
                        done_mask_next  = '0;
                        emit_cnt_next   = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEL_SCAN;
                    end
                end
            end

            ST_DUP_SCAN:
            begin
                if (pend_reg && match)
                begin
                    hit_next = 1'b1;
                end
                if (scan_done)
                begin
                    state_next = ST_DET_RES;
                end
            end

            ST_DET_RES:
            begin
                if (slot_free)
                begin
                    ov_next       = 1'b1;
                    o_stored_next = !hit_reg && (count_reg < CNT_W'(TABLE_DEPTH));
                    o_full_next   = !hit_reg && (count_reg >= CNT_W'(TABLE_DEPTH));
                    o_valid_next  = 1'b0;
                    o_entry_next  = '0;
                    o_last_next   = 1'b1;
                    if (!hit_reg && (count_reg < CNT_W'(TABLE_DEPTH)))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SEL_SCAN:
            begin
                if (pend_reg && cand)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_entry_next = rd_data_reg;
                end
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next                      = 1'b1;
                    o_stored_next                = 1'b0;
                    o_full_next                  = 1'b0;
                    o_valid_next                 = 1'b1;
                    o_entry_next                 = best_entry_reg;
                    o_last_next                  = emit_last;
                    done_mask_next[best_idx_reg] = 1'b1;
                    emit_cnt_next                = emit_cnt_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next   = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEL_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tol_reg        <= TOL_RESET;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            done_mask_reg  <= '0;
            emit_cnt_reg   <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            best_found_reg <= best_found_next;
            done_mask_reg  <= done_mask_next;
            emit_cnt_reg   <= emit_cnt_next;
            ov_reg         <= ov_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        new_reg        <= new_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        o_stored_reg   <= o_stored_next;
        o_full_reg     <= o_full_next;
        o_valid_reg    <= o_valid_next;
        o_entry_reg    <= o_entry_next;
        o_last_reg     <= o_last_next;
    end

    // entry memory: append at the fill count, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= new_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // returned read data always belongs to a filled entry
    a_pend_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pend_idx_reg < count_reg))
        else $error("scan compared an entry beyond the fill count");

    // a stored result grows the table by exactly one
    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DET_RES && slot_free && o_stored_next)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored result without table growth");

    // every selection pass over a nonempty table finds an entry
    a_sel_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL_SCAN && scan_done) |-> best_found_reg)
        else $error("selection pass ended without a candidate");

    // the final emitted entry empties the table and frees the block
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && emit_last)
        |=> (count_reg == '0 && state_reg == ST_IDLE && ov_reg && o_last_reg))
        else $error("last emitted entry did not clear the table");

    // no entry is emitted twice within one readout
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !done_mask_reg[best_idx_reg])
        else $error("entry selected a second time");

endmodule
